>>> rtl/ljpf_pkg.sv
// Shared constants, types and saturation helpers for the Lennard-Jones pair force block.
`default_nettype none

package ljpf_pkg;

  // Particle storage; the particle count is a power of two so an index wraps by truncation.
  localparam int NUM_PARTICLES = 65536;
  localparam int ADDR_W        = $clog2(NUM_PARTICLES);
  localparam int IDX_W         = 16;
  localparam int POS_W         = 32;
  localparam int MOM_W         = 48;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // Command codes carried on the input tuser field; the spare code is handled as a read.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REACTION = 2'd2;

  // Register reset values: cutoff 9.0 in Q8.24, dt 0.001 in Q0.32.
  localparam logic [31:0] CUTOFF_RST = 32'd150994944;
  localparam logic [31:0] DT_RST     = 32'd4294967;

  // Smallest squared distance used for the force, 1/8 in Q.48.
  localparam logic [57:0] R2_MIN = 58'd1 << 45;

  typedef struct packed {
    logic             sat;
    logic [MOM_W-1:0] val;
  } sat_res_t;

  // Signed 48-bit accumulate with clamping to the 48-bit range.
  function automatic sat_res_t sat_add(input logic [MOM_W-1:0] a, input logic [MOM_W:0] b);
    logic [MOM_W+1:0] sum;
    sat_res_t         res;
    sum = {{2{a[MOM_W-1]}}, a} + {b[MOM_W], b};
    res.sat = 1'b0;
    res.val = sum[MOM_W-1:0];
    if (sum[MOM_W+1:MOM_W-1] != 3'b000 && sum[MOM_W+1:MOM_W-1] != 3'b111) begin
      res.sat = 1'b1;
      res.val = sum[MOM_W+1] ? {1'b1, {(MOM_W-1){1'b0}}} : {1'b0, {(MOM_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Apply a sign to a magnitude and clamp it to the 48-bit signed range.
  function automatic sat_res_t inc_sat(input logic [103:0] m, input logic neg);
    sat_res_t res;
    res.sat = 1'b0;
    res.val = '0;
    if (m != '0) begin
      if (neg) begin
        if (m > {56'd0, 1'b1, 47'd0}) begin
          res.sat = 1'b1;
          res.val = {1'b1, {(MOM_W-1){1'b0}}};
        end else begin
          res.val = MOM_W'(-m[MOM_W-1:0]);
        end
      end else begin
        if (m > {57'd0, {(MOM_W-1){1'b1}}}) begin
          res.sat = 1'b1;
          res.val = {1'b0, {(MOM_W-1){1'b1}}};
        end else begin
          res.val = m[MOM_W-1:0];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ljpf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ljpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ljpf_mul.sv
// Multi-cycle 64x64 unsigned multiplier built from one registered 32x32 partial product.
`default_nettype none

module ljpf_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      prod
);

  logic         busy_r;
  logic         done_r;
  logic [2:0]   phase_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [127:0] pp_shift;

  // Partial product selection: low*low, low*high, high*low, high*high.
  always_comb begin
    op_a = a_r[31:0];
    op_b = b_r[31:0];
    unique case (phase_r)
      3'd1:    op_b = b_r[63:32];
      3'd2:    op_a = a_r[63:32];
      3'd3: begin
        op_a = a_r[63:32];
        op_b = b_r[63:32];
      end
      default: ;
    endcase
  end

  // Weight of the partial product that was registered in the previous phase.
  always_comb begin
    unique case (phase_r)
      3'd2, 3'd3: pp_shift = {32'd0, pp_r, 32'd0};
      3'd4:       pp_shift = {pp_r, 64'd0};
      default:    pp_shift = {64'd0, pp_r};
    endcase
  end

  // Sequencer: four products, each accumulated in the cycle after it is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= '0;
        a_r     <= a;
        b_r     <= b;
        acc_r   <= '0;
      end else if (busy_r) begin
        if (phase_r != 3'd4) begin
          pp_r <= 64'(op_a * op_b);
        end
        if (phase_r != 3'd0) begin
          acc_r <= acc_r + pp_shift;
        end
        if (phase_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        phase_r <= phase_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

>>> rtl/lj_pair_force_accumulator.sv
// Top level of the Lennard-Jones pair force accumulator with its particle memories.
//
// Input channel (in_): one command per transaction. tuser holds the command:
// write a position (and clear that particle's momentum), apply a pair force,
// or read a momentum. tdata holds index_i, index_j and the three positions.
// Result channel (out_): exactly one transaction per command, carrying the
// momentum of index_i after the command and two status flags in tuser.
// Configuration channel (cfg_): register writes, always ready; write only
// while the block is idle.
// Commands are handled one at a time. A write registers its result directly;
// a read first reads the momentum; a pair 16.0 or more apart on an axis reads
// both positions and the momentum; a pair outside the cutoff also forms the
// squared distance; an applied pair also runs the 65-step restoring divider
// for 1/r2, eleven products through one shared 32x32 multiplier and the
// momentum read-modify-write of i (and of j with the reaction update).
// The next command is accepted as soon as the previous result is registered,
// even if the receiver has not taken it; a stalled receiver holds the result
// and stops the sequencer only when the next result is ready.
// Reset restores the register defaults and empties the result register; the
// memories are not cleared, so a particle must be written before it is used.
`default_nettype none

module lj_pair_force_accumulator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: index_i[15:0], index_j[31:16], pos_x[63:32], pos_y[95:64], pos_z[127:96]
  input  wire logic [127:0] in_tdata,
  // in_tuser: command[1:0]
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata: mom_x[47:0], mom_y[95:48], mom_z[143:96]
  output logic      [143:0] out_tdata,
  // out_tuser: in_cutoff[0], saturated[1]
  output logic      [1:0]   out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ljpf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ljpf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PI, S_PJ, S_MSTART, S_MWAIT, S_CHK, S_DIV, S_FM,
    S_MOMRD, S_MOMWT, S_MRD_I, S_MADD_I, S_MRD_J, S_MADD_J, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQZ, OP_U2, OP_U4, OP_U6, OP_U7, OP_DF, OP_INCX, OP_INCY, OP_INCZ
  } mul_op_t;

  state_t            state_r;
  mul_op_t           op_r;
  logic [31:0]       cutoff_r;
  logic [31:0]       dt_r;
  logic              reaction_r;
  logic [ADDR_W-1:0] i_r;
  logic [ADDR_W-1:0] j_r;
  logic [POS_W-1:0]  posi_r [3];
  logic [27:0]       dm_r [3];
  logic [2:0]        dneg_r;
  logic [57:0]       r2_r;
  logic [39:0]       s_r;
  logic [40:0]       div_rem_r;
  logic [35:0]       div_q_r;
  logic [6:0]        div_cnt_r;
  logic [63:0]       u2_r;
  logic [63:0]       u4_r;
  logic [63:0]       u6_r;
  logic [63:0]       u7_r;
  logic [63:0]       fm_r;
  logic              fneg_r;
  logic [63:0]       dfm_r;
  logic [MOM_W-1:0]  inc_r [3];
  logic [MOM_W-1:0]  mom_res_r [3];
  logic              hit_r;
  logic              sat_r;
  logic              out_tvalid_r;
  logic [143:0]      out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic              in_acc;
  logic [1:0]        in_cmd;
  logic [ADDR_W-1:0] in_idx_i;
  logic [ADDR_W-1:0] in_idx_j;

  logic              pos_we;
  logic              pos_re;
  logic [ADDR_W-1:0] pos_raddr;
  logic [95:0]       pos_rdata;
  logic [POS_W-1:0]  posj [3];
  logic              mom_we;
  logic              mom_re;
  logic [ADDR_W-1:0] mom_waddr;
  logic [ADDR_W-1:0] mom_raddr;
  logic [143:0]      mom_wdata;
  logic [143:0]      mom_rdata;
  sat_res_t          mom_upd [3];

  logic              mul_start;
  logic              mul_done;
  logic [63:0]       mul_a;
  logic [63:0]       mul_b;
  logic [127:0]      mul_prod;

  logic [32:0]       d_full [3];
  logic [32:0]       d_mag [3];
  logic              far;
  logic [57:0]       r2_clamp;
  logic [40:0]       rem_sh;
  logic              q_bit;
  logic [40:0]       rem_next;
  logic [63:0]       f_a;
  logic [63:0]       f_b;
  sat_res_t          inc_new;

  // Input field extraction; indexes wrap to the particle count.
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tuser;
  assign in_idx_i  = in_tdata[ADDR_W-1:0];
  assign in_idx_j  = in_tdata[IDX_W+ADDR_W-1:IDX_W];
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Position memory: x, y, z packed from the low bits.
  assign pos_we    = in_acc && (in_cmd == CMD_WRITE);
  assign pos_re    = (in_acc && (in_cmd == CMD_PAIR)) || (state_r == S_PI);
  assign pos_raddr = (state_r == S_IDLE) ? in_idx_i : j_r;

  ljpf_ram #(.WIDTH(96), .DEPTH(NUM_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (in_idx_i),
    .wdata (in_tdata[127:32]),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // Momentum memory: read-modify-write of particle i, then of particle j when the reaction update is on.
  assign mom_re = (in_acc && (in_cmd == CMD_READ || in_cmd == CMD_SPARE)) ||
                  (state_r == S_MOMRD) || (state_r == S_MRD_I) || (state_r == S_MRD_J);
  assign mom_raddr = (state_r == S_IDLE) ? in_idx_i : ((state_r == S_MRD_J) ? j_r : i_r);
  assign mom_we    = (in_acc && (in_cmd == CMD_WRITE)) ||
                     (state_r == S_MADD_I) || (state_r == S_MADD_J);
  assign mom_waddr = (state_r == S_IDLE) ? in_idx_i : ((state_r == S_MADD_J) ? j_r : i_r);
  assign mom_wdata = (state_r == S_IDLE) ? '0 :
                     {mom_upd[2].val, mom_upd[1].val, mom_upd[0].val};

  ljpf_ram #(.WIDTH(144), .DEPTH(NUM_PARTICLES)) u_mom_ram (
    .clk   (clk),
    .we    (mom_we),
    .waddr (mom_waddr),
    .wdata (mom_wdata),
    .re    (mom_re),
    .raddr (mom_raddr),
    .rdata (mom_rdata)
  );

  // Momentum update: i gains the increment, j loses it.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mom_upd[k] = sat_add(mom_rdata[MOM_W*k +: MOM_W],
                           (state_r == S_MADD_J) ? (MOM_W+1)'(-{inc_r[k][MOM_W-1], inc_r[k]})
                                                 : {inc_r[k][MOM_W-1], inc_r[k]});
    end
  end

  // Distance vector of the pair and the far test on each component.
  always_comb begin
    far = 1'b0;
    for (int k = 0; k < 3; k++) begin
      posj[k]   = pos_rdata[POS_W*k +: POS_W];
      d_full[k] = {posj[k][POS_W-1], posj[k]} - {posi_r[k][POS_W-1], posi_r[k]};
      d_mag[k]  = d_full[k][32] ? 33'(-d_full[k]) : d_full[k];
      if (d_mag[k][32:28] != '0) begin
        far = 1'b1;
      end
    end
  end

  // Close approach clamps r2 to 1/8 before the reciprocal.
  assign r2_clamp = (r2_r < R2_MIN) ? R2_MIN : r2_r;

  // One restoring division step of 2^64 by s.
  assign rem_sh   = {div_rem_r[39:0], (div_cnt_r == 7'd0)};
  assign q_bit    = (rem_sh >= {1'b0, s_r});
  assign rem_next = q_bit ? (rem_sh - {1'b0, s_r}) : rem_sh;

  // Force magnitude terms 24*u^4 and 48*u^7.
  assign f_a = (u4_r << 4) + (u4_r << 3);
  assign f_b = (u7_r << 5) + (u7_r << 4);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_r)
      OP_SQX: begin mul_a = {36'd0, dm_r[0]}; mul_b = {36'd0, dm_r[0]}; end
      OP_SQY: begin mul_a = {36'd0, dm_r[1]}; mul_b = {36'd0, dm_r[1]}; end
      OP_SQZ: begin mul_a = {36'd0, dm_r[2]}; mul_b = {36'd0, dm_r[2]}; end
      OP_U2:  begin mul_a = {28'd0, div_q_r}; mul_b = {28'd0, div_q_r}; end
      OP_U4:  begin mul_a = u2_r; mul_b = u2_r; end
      OP_U6:  begin mul_a = u4_r; mul_b = u2_r; end
      OP_U7:  begin mul_a = u6_r; mul_b = {28'd0, div_q_r}; end
      OP_DF:  begin mul_a = fm_r; mul_b = {32'd0, dt_r}; end
      OP_INCX: begin mul_a = dfm_r; mul_b = {36'd0, dm_r[0]}; end
      OP_INCY: begin mul_a = dfm_r; mul_b = {36'd0, dm_r[1]}; end
      OP_INCZ: begin mul_a = dfm_r; mul_b = {36'd0, dm_r[2]}; end
      default: ;
    endcase
  end

  // Signed, clamped increment for the component in work.
  always_comb begin
    unique case (op_r)
      OP_INCY: inc_new = inc_sat(mul_prod[127:24], fneg_r ^ dneg_r[1]);
      OP_INCZ: inc_new = inc_sat(mul_prod[127:24], fneg_r ^ dneg_r[2]);
      default: inc_new = inc_sat(mul_prod[127:24], fneg_r ^ dneg_r[0]);
    endcase
  end

  assign mul_start = (state_r == S_MSTART);

  ljpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Command sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_SQX;
      cutoff_r     <= CUTOFF_RST;
      dt_r         <= DT_RST;
      reaction_r   <= 1'b1;
      out_tvalid_r <= 1'b0;
      hit_r        <= 1'b0;
      sat_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CUTOFF:   cutoff_r   <= cfg_data;
          CFG_DT:       dt_r       <= cfg_data;
          CFG_REACTION: reaction_r <= cfg_data[0];
          default: ;
        endcase
      end

      // The result register empties when taken, unless a new result loads it.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            i_r   <= in_idx_i;
            j_r   <= in_idx_j;
            hit_r <= 1'b0;
            sat_r <= 1'b0;
            if (in_cmd == CMD_WRITE) begin
              for (int k = 0; k < 3; k++) mom_res_r[k] <= '0;
              state_r <= S_OUT;
            end else if (in_cmd == CMD_PAIR) begin
              state_r <= S_PI;
            end else begin
              state_r <= S_MOMWT;
            end
          end
        end
        S_PI: begin
          for (int k = 0; k < 3; k++) posi_r[k] <= pos_rdata[POS_W*k +: POS_W];
          state_r <= S_PJ;
        end
        S_PJ: begin
          for (int k = 0; k < 3; k++) begin
            dm_r[k]   <= d_mag[k][27:0];
            dneg_r[k] <= d_full[k][32];
          end
          op_r    <= OP_SQX;
          state_r <= far ? S_MOMRD : S_MSTART;
        end
        S_MSTART: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            state_r <= S_MSTART;
            unique case (op_r)
              OP_SQX: begin r2_r <= mul_prod[57:0]; op_r <= OP_SQY; end
              OP_SQY: begin r2_r <= r2_r + mul_prod[57:0]; op_r <= OP_SQZ; end
              OP_SQZ: begin r2_r <= r2_r + mul_prod[57:0]; state_r <= S_CHK; end
              OP_U2:  begin u2_r <= mul_prod[95:32]; op_r <= OP_U4; end
              OP_U4:  begin u4_r <= mul_prod[95:32]; op_r <= OP_U6; end
              OP_U6:  begin u6_r <= mul_prod[95:32]; op_r <= OP_U7; end
              OP_U7:  begin u7_r <= mul_prod[95:32]; state_r <= S_FM; end
              OP_DF:  begin dfm_r <= mul_prod[95:32]; op_r <= OP_INCX; end
              OP_INCX: begin
                inc_r[0] <= inc_new.val;
                sat_r    <= sat_r | inc_new.sat;
                op_r     <= OP_INCY;
              end
              OP_INCY: begin
                inc_r[1] <= inc_new.val;
                sat_r    <= sat_r | inc_new.sat;
                op_r     <= OP_INCZ;
              end
              OP_INCZ: begin
                inc_r[2] <= inc_new.val;
                sat_r    <= sat_r | inc_new.sat;
                state_r  <= S_MRD_I;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_CHK: begin
          if (r2_r == '0) begin
            sat_r   <= 1'b1;
            state_r <= S_MOMRD;
          end else if (r2_r > {2'd0, cutoff_r, 24'd0}) begin
            state_r <= S_MOMRD;
          end else begin
            hit_r     <= 1'b1;
            sat_r     <= sat_r | (r2_r < R2_MIN);
            s_r       <= r2_clamp[55:16];
            div_rem_r <= '0;
            div_q_r   <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_r <= rem_next;
          div_q_r   <= {div_q_r[34:0], q_bit};
          div_cnt_r <= div_cnt_r + 7'd1;
          if (div_cnt_r == 7'd64) begin
            op_r    <= OP_U2;
            state_r <= S_MSTART;
          end
        end
        S_FM: begin
          fneg_r  <= (f_b > f_a);
          fm_r    <= (f_b > f_a) ? (f_b - f_a) : (f_a - f_b);
          op_r    <= OP_DF;
          state_r <= S_MSTART;
        end
        S_MOMRD: begin
          state_r <= S_MOMWT;
        end
        S_MOMWT: begin
          for (int k = 0; k < 3; k++) mom_res_r[k] <= mom_rdata[MOM_W*k +: MOM_W];
          state_r <= S_OUT;
        end
        S_MRD_I: begin
          state_r <= S_MADD_I;
        end
        S_MADD_I: begin
          for (int k = 0; k < 3; k++) mom_res_r[k] <= mom_upd[k].val;
          sat_r   <= sat_r | mom_upd[0].sat | mom_upd[1].sat | mom_upd[2].sat;
          state_r <= reaction_r ? S_MRD_J : S_OUT;
        end
        S_MRD_J: begin
          state_r <= S_MADD_J;
        end
        S_MADD_J: begin
          sat_r   <= sat_r | mom_upd[0].sat | mom_upd[1].sat | mom_upd[2].sat;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {mom_res_r[2], mom_res_r[1], mom_res_r[0]};
            out_tuser_r  <= {sat_r, hit_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The multiplier only reports a product while the sequencer waits for one.
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MWAIT)
    else $error("multiplier finished outside its wait state");

  // A momentum write never coincides with a read of the same entry.
  a_mom_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mom_we && mom_re) |-> mom_waddr != mom_raddr)
    else $error("momentum read and write collide");

  // An accepted command always starts work on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted command did not start");

  // The reciprocal is only started for a pair already marked in cutoff.
  a_hit_not_far: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> hit_r)
    else $error("reciprocal started for a pair not in cutoff");

endmodule

`default_nettype wire
